// ----- rtl/msce_pkg.sv -----
// Shared constants, types and arithmetic helpers for the contrast enhance unit.
package msce_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int LineDepth = 8 * MaxWidth + 16;
    localparam int AddrW     = $clog2(LineDepth);
    localparam int DimW      = 11;
    localparam int PosW      = 22;
    localparam int CoordW    = 12;

    localparam logic [1:0] RegFrameWidth  = 2'd0;
    localparam logic [1:0] RegFrameHeight = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } state_t;

    // lightened pixel: min(p*12/10, 255)
    function automatic logic [7:0] lighten(input logic [7:0] v);
        logic [11:0] m;
        logic [11:0] q;
        begin
            m = {4'd0, v} * 12'd12;
            q = 12'(({8'd0, m} * 20'd205) >> 11);
            if ({8'd0, q} * 20'd10 > {8'd0, m}) q = q - 12'd1;
            lighten = (q > 12'd255) ? 8'd255 : q[7:0];
        end
    endfunction

    // darkened pixel: p*10/12
    function automatic logic [7:0] darken(input logic [7:0] v);
        logic [11:0] m;
        logic [11:0] q;
        begin
            m = {4'd0, v} * 12'd10;
            q = 12'(({8'd0, m} * 20'd171) >> 11);
            if ({8'd0, q} * 20'd12 > {8'd0, m}) q = q - 12'd1;
            darken = q[7:0];
        end
    endfunction

endpackage

// ----- rtl/msce_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module msce_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/msce_divider.sv -----
// Restoring divider, one quotient bit per cycle, for p*blur3/blur9.
module msce_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic        done,
    output logic [15:0] quotient
);
    import msce_pkg::*;

    logic [15:0] q_reg, q_next;
    logic [8:0]  r_reg, r_next;
    logic [7:0]  d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [8:0]  trial;

    assign quotient = q_reg;
    assign done     = busy_reg && (cnt_reg == 5'd0);

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[7:0], q_reg[15]};
        if (start) begin
            q_next    = dividend;
            r_next    = 9'd0;
            d_next    = divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
            end else begin
                if (trial >= {1'b0, d_reg}) begin
                    r_next = trial - {1'b0, d_reg};
                    q_next = {q_reg[14:0], 1'b1};
                end else begin
                    r_next = trial;
                    q_next = {q_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

// ----- rtl/multistencil_contrast_enhance_unit.sv -----
// Top level: sequencer around the line store, window accumulation and output stage.
//
// Input channel s_ (func, pixel) with valid/ready; result channel m_ (result_pixel,
// frame_last) with valid/ready. frame_width and frame_height are set over the APB
// port at 0x0 and 0x4; a write restarts the frame. Pixels arrive in raster order;
// results come out in raster order, lagging the input by 4*width+4 items. After
// the last pixel of a frame, drain items (func=1) push out the remaining results.
// A drain item during the pixel phase is dropped.
// Sequence: an item that yields a result reads from the single read port of the line
// store (81 window taps plus the center pixel), forms the 3x3 and 9x9 averages,
// runs a bit-serial divide and drives the output register; the divide is skipped
// when the 9x9 average is zero. The next item is taken only after the output step,
// so items do not overlap. An item that yields no result leaves the sequencer idle.
// A result waits in the output register while the receiver stalls; the next item
// is taken only once that result has gone.
// Reset restores 480x640 and clears all position counters; the line store is
// not cleared, since no entry is read before it has been written in the frame.
module multistencil_contrast_enhance_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_result_pixel,
    output logic        m_frame_last
);
    import msce_pkg::*;

    state_t state_reg, state_next;
    logic [DimW-1:0] fw_reg, fh_reg;
    logic [DimW-1:0] w, h;
    logic [DimW-1:0] in_col_reg, in_row_reg, out_col_reg, out_row_reg;
    logic [DimW-1:0] in_col_next, in_row_next, out_col_next, out_row_next;
    logic [6:0]  tap_reg, tap_next;
    logic [3:0]  tx_reg, tx_next, ty_reg, ty_next;
    logic [3:0]  rtx_reg, rty_reg;
    logic [AddrW-1:0] waddr_reg, waddr_next, oaddr_reg, oaddr_next;
    logic        rvld_reg;
    logic [6:0]  rtap_reg;
    logic [11:0] s3_reg;
    logic [14:0] s9_reg;
    logic [7:0]  pc_reg;
    logic [7:0]  b3_reg, b9_reg;
    logic [15:0] prod;
    logic        last_reg;
    logic [7:0]  res_reg;
    logic        mvalid_reg;
    logic        cfg_wr;
    logic        accept;
    logic        pixel_phase;
    logic        eff_drain;
    logic [PosW-1:0] pos;
    logic        emits;
    logic [AddrW-1:0] raddr;
    logic [7:0]  rdata;
    logic        div_start, div_done;
    logic [15:0] div_q;
    logic signed [CoordW:0] cx, cy;
    logic signed [CoordW:0] ddx, ddy;
    logic signed [15:0] roff, rsum;
    logic [DimW-1:0] fx, fy;
    logic        in_win3;
    logic [23:0] s3_prod;
    logic [26:0] s9_prod;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        w = (fw_reg == '0) ? DimW'(1) : (fw_reg > DimW'(MaxWidth)) ? DimW'(MaxWidth) : fw_reg;
        h = (fh_reg == '0) ? DimW'(1) : (fh_reg > DimW'(MaxHeight)) ? DimW'(MaxHeight) : fh_reg;
    end

    always_comb begin
        unique case (paddr[2])
            RegFrameWidth[0]:  prdata = {21'd0, fw_reg};
            default:           prdata = {21'd0, fh_reg};
        endcase
    end

    assign s_ready     = (state_reg == ST_IDLE) && !mvalid_reg;
    assign accept      = s_valid && s_ready;
    assign pixel_phase = in_row_reg < h;
    assign eff_drain   = pixel_phase && s_func;
    assign pos         = PosW'(in_row_reg) * PosW'(w) + PosW'(in_col_reg);
    assign emits       = pos >= PosW'({w, 2'b00}) + PosW'(4);

    // taps 0..80 walk the 9x9 window, tap 81 is the center pixel; the address is
    // formed relative to the result position, which every tap lies within 4 rows of
    always_comb begin
        if (tap_reg == 7'd81) begin
            cx = $signed({2'b0, out_col_reg});
            cy = $signed({2'b0, out_row_reg});
        end else begin
            cx = $signed({2'b0, out_col_reg}) + $signed({9'd0, tx_reg}) - 13'sd4;
            cy = $signed({2'b0, out_row_reg}) + $signed({9'd0, ty_reg}) - 13'sd4;
        end
        if (cx < 0) fx = '0;
        else if (cx > $signed({2'b0, w - DimW'(1)})) fx = w - DimW'(1);
        else fx = cx[DimW-1:0];
        if (cy < 0) fy = '0;
        else if (cy > $signed({2'b0, h - DimW'(1)})) fy = h - DimW'(1);
        else fy = cy[DimW-1:0];
        ddx  = $signed({2'b0, fx}) - $signed({2'b0, out_col_reg});
        ddy  = $signed({2'b0, fy}) - $signed({2'b0, out_row_reg});
        roff = 16'(ddy) * $signed({5'd0, w}) + 16'(ddx);
        rsum = $signed({2'b0, oaddr_reg}) + roff;
        if (rsum < 0) raddr = rsum[AddrW-1:0] + AddrW'(LineDepth);
        else if (rsum >= 16'(LineDepth)) raddr = rsum[AddrW-1:0] - AddrW'(LineDepth);
        else raddr = rsum[AddrW-1:0];
    end

    msce_ram #(.Width(8), .Depth(LineDepth)) u_line (
        .aclk  (aclk),
        .we    (accept && pixel_phase && !s_func),
        .waddr (waddr_reg),
        .wdata (s_pixel),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign prod      = 16'(pc_reg) * 16'(b3_reg);
    assign div_start = (state_reg == ST_CALC) && !rvld_reg && (b9_reg != 8'd0);

    msce_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod),
        .divisor  (b9_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_win3 = (rty_reg >= 4'd3) && (rty_reg <= 4'd5)
                  && (rtx_reg >= 4'd3) && (rtx_reg <= 4'd5);
    assign s3_prod = 24'(s3_reg) * 24'd7282;
    assign s9_prod = 27'(s9_reg) * 27'd6473;

    always_comb begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        waddr_next   = waddr_reg;
        oaddr_next   = oaddr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !eff_drain) begin
                    waddr_next = (waddr_reg == AddrW'(LineDepth - 1)) ? '0
                                                                       : waddr_reg + AddrW'(1);
                    if (in_col_reg + DimW'(1) >= w) begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + DimW'(1);
                    end else begin
                        in_col_next = in_col_reg + DimW'(1);
                    end
                    if (emits) begin
                        tap_next   = '0;
                        tx_next    = '0;
                        ty_next    = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (tap_reg == 7'd81) begin
                    state_next = ST_CALC;
                end else begin
                    tap_next = tap_reg + 7'd1;
                    if (tx_reg == 4'd8) begin
                        tx_next = '0;
                        ty_next = ty_reg + 4'd1;
                    end else begin
                        tx_next = tx_reg + 4'd1;
                    end
                end
            end
            ST_CALC: begin
                if (!rvld_reg) state_next = (b9_reg == 8'd0) ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                state_next = ST_IDLE;
                oaddr_next = (oaddr_reg == AddrW'(LineDepth - 1)) ? '0
                                                                   : oaddr_reg + AddrW'(1);
                if (last_reg) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    waddr_next   = '0;
                    oaddr_next   = '0;
                end else if (out_col_reg + DimW'(1) >= w) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + DimW'(1);
                end else begin
                    out_col_next = out_col_reg + DimW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_wr) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            waddr_next   = '0;
            oaddr_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fw_reg      <= DimW'(480);
            fh_reg      <= DimW'(640);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            waddr_reg   <= '0;
            oaddr_reg   <= '0;
            mvalid_reg  <= 1'b0;
            rvld_reg    <= 1'b0;
            tap_reg     <= '0;
            tx_reg      <= '0;
            ty_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            tx_reg      <= tx_next;
            ty_reg      <= ty_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            waddr_reg   <= waddr_next;
            oaddr_reg   <= oaddr_next;
            rvld_reg    <= (state_reg == ST_READ);
            if (cfg_wr) begin
                if (paddr[2] == RegFrameWidth[0]) fw_reg <= pwdata[DimW-1:0];
                else fh_reg <= pwdata[DimW-1:0];
            end
            if (state_reg == ST_OUT) mvalid_reg <= 1'b1;
            else if (m_ready) mvalid_reg <= 1'b0;
        end
        rtap_reg <= tap_reg;
        rtx_reg  <= tx_reg;
        rty_reg  <= ty_reg;
        if (accept) begin
            s3_reg <= '0;
            s9_reg <= '0;
        end
        if (rvld_reg) begin
            if (rtap_reg == 7'd81) begin
                pc_reg <= rdata;
            end else begin
                s9_reg <= s9_reg + 15'(darken(rdata));
                if (in_win3) s3_reg <= s3_reg + 12'(lighten(rdata));
            end
        end
        if (state_reg == ST_CALC) begin
            if (rvld_reg) begin
                b3_reg <= 8'(s3_prod >> 16);
                b9_reg <= 8'(s9_prod >> 19);
            end
        end
        if (state_reg == ST_READ && tap_reg == 7'd0) begin
            last_reg <= (out_col_reg == w - DimW'(1)) && (out_row_reg == h - DimW'(1));
        end
        if (state_reg == ST_CALC && !rvld_reg && b9_reg == 8'd0) res_reg <= 8'd0;
        if (state_reg == ST_DIV && div_done)
            res_reg <= (div_q > 16'd255) ? 8'd255 : div_q[7:0];
    end

    assign m_valid        = mvalid_reg;
    assign m_result_pixel = res_reg;
    assign m_frame_last   = last_reg;
endmodule
